// ===== design/rde_pkg.sv =====
// shared types, constants and helpers for the radix digit emitter
package rde_pkg;

  localparam int MAX_DIGITS_DEF = 24;
  localparam int MAX_PAD_DEF    = 64;

  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 8;
  localparam int PADW_W  = 7;
  localparam int REM_W   = 5;

  localparam logic [REM_W-1:0]  BASE_DEC   = 5'd10;
  localparam logic [REM_W-1:0]  BASE_HEX   = 5'd16;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LC_A = 8'h61;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PAD,
    ST_EMIT
  } rde_state_t;

  typedef struct packed {
    logic start;
    logic hex;
  } rde_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rde_div_sts_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_LC_A + CHAR_W'(d) - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== design/rde_if.sv =====
// valid/ready channel interfaces for the input number and the output characters
interface rde_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        func;
  logic [6:0]  pad_width;

  modport source (output valid, value, func, pad_width, input ready);
  modport sink   (input valid, value, func, pad_width, output ready);
endinterface

interface rde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// ===== design/rde_div.sv =====
// nibble-serial divider by 10 or 16, four quotient bits per cycle
module rde_div
  import rde_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rde_div_ctl_t       ctl,
  input  logic [VALUE_W-1:0] value,
  output rde_div_sts_t       sts,
  output logic [VALUE_W-1:0] quotient,
  output logic [REM_W-1:0]   remainder
);

  localparam int STEP_W   = 4;
  localparam int STEPS    = VALUE_W / STEP_W;
  localparam int CNT_W    = $clog2(STEPS);
  localparam int TRIAL_W  = 2 * STEP_W;
  localparam int PROD_W   = 15;
  localparam int RECIP_SH = 11;
  localparam logic [PROD_W-1:0] RECIP_10 = 15'd205;

  logic [VALUE_W-1:0] quo;
  logic [REM_W-1:0]   rest;
  logic [REM_W-1:0]   base;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  logic [TRIAL_W-1:0] trial;
  logic [PROD_W-1:0]  prod;
  logic [STEP_W-1:0]  qdig;
  logic [TRIAL_W-1:0] rdig;

  // bring the next dividend nibble into the partial remainder and divide it by the base
  // (x * 205) >> 11 equals x / 10 for every x below 1029; here x stays below 160
  always_comb begin
    trial = {rest[STEP_W-1:0], quo[VALUE_W-1 -: STEP_W]};
    prod  = PROD_W'(trial) * RECIP_10;
    if (base == BASE_HEX) begin
      qdig = trial[TRIAL_W-1 -: STEP_W];
      rdig = {{STEP_W{1'b0}}, trial[STEP_W-1:0]};
    end else begin
      qdig = prod[RECIP_SH +: STEP_W];
      rdig = trial - {1'b0, qdig, 3'b000} - {3'b000, qdig, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rest <= '0;
      quo  <= '0;
      base <= BASE_DEC;
    end else if (ctl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rest <= '0;
      quo  <= value;
      base <= ctl.hex ? BASE_HEX : BASE_DEC;
    end else if (busy) begin
      quo  <= {quo[VALUE_W-STEP_W-1:0], qdig};
      rest <= rdig[REM_W-1:0];
      cnt  <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign quotient  = quo;
  assign remainder = rest;

endmodule

// ===== design/radix_digit_emitter.sv =====
// top level: 64-bit unsigned to ascii decimal or hex with leading zero padding
//
//  channel | dir | payload                      | accepted when
//  din     | in  | value, func, pad_width       | din.valid && din.ready
//  dout    | out | character, last              | dout.valid && dout.ready
//
// each digit takes 16 four-bit steps in the shared divider, after which its
// remainder is stored and the divider restarts on the quotient while it is nonzero
// din.ready is high only while the sequencer is idle; one item at a time
// dout has an output register, so a stalled dout just holds the sequencer
// synchronous reset clears the sequencer, counts and the output valid
module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_PAD    = MAX_PAD_DEF
) (
  input logic       clk,
  input logic       rst,
  rde_in_if.sink    din,
  rde_out_if.source dout
);

  localparam int DC_W = $clog2(MAX_DIGITS + 1);
  localparam int IX_W = $clog2(MAX_DIGITS);
  localparam int PR_W = $clog2(MAX_PAD + 1);
  localparam int CMP_W = 8;

  rde_state_t state, state_next;

  logic [3:0]       digit_store [MAX_DIGITS];
  logic [DC_W-1:0]  digit_count, digit_count_next;
  logic [PR_W-1:0]  pad_remaining, pad_remaining_next;
  logic [PR_W-1:0]  pad_sat;
  logic             hex;

  logic             out_valid, out_valid_next;
  logic [CHAR_W-1:0] out_char, out_char_next;
  logic             out_last, out_last_next;

  rde_div_ctl_t       div_ctl;
  rde_div_sts_t       div_sts;
  logic [VALUE_W-1:0] div_value;
  logic [VALUE_W-1:0] div_quo;
  logic [REM_W-1:0]   div_rem;

  logic              accept;
  logic              slot_free;
  logic              store_wr;
  logic [DC_W-1:0]   count_after;
  logic [CMP_W-1:0]  width_ext;
  logic [CMP_W-1:0]  count_ext;
  logic [IX_W-1:0]   rd_idx;

  assign accept    = din.valid && din.ready;
  assign slot_free = !out_valid || dout.ready;
  assign rd_idx    = IX_W'(digit_count - 1'b1);

  rde_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .value     (div_value),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      digit_count   <= '0;
      pad_remaining <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      digit_count   <= digit_count_next;
      pad_remaining <= pad_remaining_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_char <= out_char_next;
    out_last <= out_last_next;
    if (accept) begin
      hex     <= din.func;
      pad_sat <= (din.pad_width > PADW_W'(MAX_PAD)) ? PR_W'(MAX_PAD)
                                                    : PR_W'(din.pad_width);
    end
    if (store_wr) begin
      digit_store[IX_W'(digit_count)] <= div_rem[3:0];
    end
  end

  always_comb begin
    state_next         = state;
    digit_count_next   = digit_count;
    pad_remaining_next = pad_remaining;
    out_valid_next     = out_valid && !dout.ready;
    out_char_next      = out_char;
    out_last_next      = out_last;
    div_ctl.start      = 1'b0;
    div_ctl.hex        = hex;
    div_value          = div_quo;
    store_wr           = 1'b0;
    count_after        = digit_count;
    width_ext          = CMP_W'(pad_sat);
    count_ext          = '0;

    case (state)
      ST_IDLE: begin
        div_value   = din.value;
        div_ctl.hex = din.func;
        if (accept) begin
          div_ctl.start    = 1'b1;
          digit_count_next = '0;
          state_next       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          // further digits past the store are dropped
          if (digit_count < DC_W'(MAX_DIGITS)) begin
            store_wr    = 1'b1;
            count_after = digit_count + 1'b1;
          end
          digit_count_next = count_after;
          count_ext        = CMP_W'(count_after);
          if (div_quo != '0) begin
            div_ctl.start = 1'b1;
          end else begin
            pad_remaining_next = (width_ext > count_ext) ?
                                 PR_W'(width_ext - count_ext) : '0;
            state_next         = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_remaining == '0) begin
          state_next = ST_EMIT;
        end else if (slot_free) begin
          out_valid_next     = 1'b1;
          out_char_next      = ASCII_ZERO;
          out_last_next      = 1'b0;
          pad_remaining_next = pad_remaining - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next   = 1'b1;
          out_char_next    = to_ascii(digit_store[rd_idx]);
          out_last_next    = (digit_count == DC_W'(1));
          digit_count_next = digit_count - 1'b1;
          if (digit_count == DC_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign din.ready      = (state == ST_IDLE);
  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.last      = out_last;

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_DIV) && div_sts.busy)
    else $error("accepted item did not start the divider");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (digit_count != '0))
    else $error("emit state with no stored digit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= DC_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_div_only_when_dividing: assert property (@(posedge clk) disable iff (rst)
    div_sts.busy |-> (state == ST_DIV))
    else $error("divider busy outside the divide state");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && slot_free && digit_count == DC_W'(1)) |=>
      (state == ST_IDLE) && dout.valid && dout.last)
    else $error("final digit not flagged last");

endmodule
